// ===== rtl/ffba_pkg.sv =====
// ffba_pkg: word types and constants for the first-fit block allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int unsigned OWNER_W = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned RANGE_W = 6;

  // request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [OWNER_W-1:0] process_id;
    logic [COUNT_W-1:0] instruction_count;
    logic [RANGE_W-1:0] range_start;
    logic [RANGE_W-1:0] range_end;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic [RANGE_W-1:0] block_start;
    logic [RANGE_W-1:0] block_end;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/ffba_ram.sv =====
// ffba_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/first_fit_block_allocator_core.sv =====
// first_fit_block_allocator_core: owner map of a word memory with first-fit allocate and free
// depends on ffba_pkg and ffba_ram
`timescale 1ns / 1ps
`default_nettype none

// The owner map lives in one ram entry per word ({taken, owner id}). After reset a clearing
// pass writes every entry to free, during which in_ready stays low. An allocate request
// needs HEADER_WORDS + VARIABLE_SLOTS + instruction_count words; the block reads the map
// one word per cycle from word 0 with a run counter, stops at the first run long enough,
// then writes the owner into each word of the run, one per cycle. If no run fits, the
// whole map is read before the answer; a size of zero or above WORD_COUNT is answered
// without a scan. A free request reads each word of its range once and frees the matching
// ones behind the read; a bad range is answered without a read. The single ram read port
// sets the pace: one word per cycle. One request is in work at a time; in_ready is low
// from accept until the result has moved into the output register.
module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int unsigned WORD_COUNT     = 64,
  parameter int unsigned HEADER_WORDS   = 4,
  parameter int unsigned VARIABLE_SLOTS = 3
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  localparam int unsigned AW      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  // counter width holds WORD_COUNT itself and any request size
  localparam int unsigned CNT_W   = (AW + 1 > 8) ? AW + 1 : 8;
  localparam int unsigned ENTRY_W = OWNER_W + 1;
  localparam logic [CNT_W-1:0] WC_C     = CNT_W'(WORD_COUNT);
  localparam logic [CNT_W-1:0] OVERHEAD = CNT_W'(HEADER_WORDS + VARIABLE_SLOTS);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_MARK  = 6'b001000,
    ST_FREE  = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  // control registers
  state_t           state_r,     state_nxt;
  logic [CNT_W-1:0] addr_r,      addr_nxt;      // next word to read, or clear pointer
  logic             rd_vld_r,    rd_vld_nxt;    // ram read data is valid for chk_addr_r
  logic             out_valid_r, out_valid_nxt;

  // payload registers
  logic [AW-1:0]      chk_addr_r,  chk_addr_nxt;
  logic [CNT_W-1:0]   run_r,       run_nxt;
  logic [CNT_W-1:0]   len_r,       len_nxt;
  logic [CNT_W-1:0]   last_r,      last_nxt;     // last word of a free range
  logic [AW-1:0]      end_r,       end_nxt;      // last word of a found run
  logic [AW-1:0]      mark_addr_r, mark_addr_nxt;
  logic [OWNER_W-1:0] pid_r,       pid_nxt;
  out_word_t          res_r,       res_nxt;
  out_word_t          out_word_r,  out_word_nxt;

  // ram port
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic               in_fire;
  logic [CNT_W-1:0]   req_len;
  logic [CNT_W-1:0]   run_inc;
  logic [CNT_W-1:0]   chk_ext;
  logic [CNT_W-1:0]   run_start;
  logic               rd_taken;
  logic [OWNER_W-1:0] rd_owner;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign req_len   = OVERHEAD + CNT_W'(in_word.instruction_count);
  assign run_inc   = run_r + CNT_W'(1);
  assign chk_ext   = CNT_W'(chk_addr_r);
  // start of a run that ends at the word under check
  assign run_start = chk_ext + CNT_W'(1) - len_r;
  assign rd_taken  = ram_rd_data[OWNER_W];
  assign rd_owner  = ram_rd_data[OWNER_W-1:0];

  ffba_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WORD_COUNT)
  ) u_owner_map (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    chk_addr_nxt  = chk_addr_r;
    run_nxt       = run_r;
    len_nxt       = len_r;
    last_nxt      = last_r;
    end_nxt       = end_r;
    mark_addr_nxt = mark_addr_r;
    pid_nxt       = pid_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;

    ram_wr_en     = 1'b0;
    ram_wr_addr   = addr_r[AW-1:0];
    ram_wr_data   = '0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = addr_r[AW-1:0];

    // output register drains independently of the sequencer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        // clearing pass: every word free, owner zero
        ram_wr_en   = 1'b1;
        ram_wr_addr = addr_r[AW-1:0];
        ram_wr_data = '0;
        addr_nxt    = addr_r + CNT_W'(1);
        if (addr_r == WC_C - CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          pid_nxt  = in_word.process_id;
          res_nxt  = '0;
          addr_nxt = '0;
          run_nxt  = '0;
          if (in_word.action == ACT_ALLOC) begin
            len_nxt = req_len;
            if (req_len == '0 || req_len > WC_C) begin
              state_nxt = ST_RESP;
            end else begin
              state_nxt = ST_SCAN;
            end
          end else begin
            addr_nxt = CNT_W'(in_word.range_start);
            last_nxt = CNT_W'(in_word.range_end);
            if (in_word.range_start <= in_word.range_end &&
                CNT_W'(in_word.range_end) < WC_C) begin
              state_nxt = ST_FREE;
            end else begin
              state_nxt = ST_RESP;
            end
          end
        end
      end

      ST_SCAN: begin
        // read one word ahead, check the word read last cycle
        ram_rd_en    = (addr_r < WC_C);
        ram_rd_addr  = addr_r[AW-1:0];
        rd_vld_nxt   = ram_rd_en;
        chk_addr_nxt = addr_r[AW-1:0];
        if (ram_rd_en) begin
          addr_nxt = addr_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (rd_taken) begin
            run_nxt = '0;
          end else if (run_inc == len_r) begin
            // run complete: claim it
            end_nxt             = chk_addr_r;
            mark_addr_nxt       = run_start[AW-1:0];
            res_nxt.ok          = 1'b1;
            res_nxt.block_start = run_start[RANGE_W-1:0];
            res_nxt.block_end   = chk_ext[RANGE_W-1:0];
            state_nxt           = ST_MARK;
          end else begin
            run_nxt = run_inc;
          end
        end else if (!ram_rd_en) begin
          // whole map checked without a fit
          state_nxt = ST_RESP;
        end
      end

      ST_MARK: begin
        ram_wr_en     = 1'b1;
        ram_wr_addr   = mark_addr_r;
        ram_wr_data   = {1'b1, pid_r};
        mark_addr_nxt = mark_addr_r + AW'(1);
        if (mark_addr_r == end_r) begin
          state_nxt = ST_RESP;
        end
      end

      ST_FREE: begin
        // read each word of the range, free it in the next cycle if the owner matches
        ram_rd_en    = (addr_r <= last_r);
        ram_rd_addr  = addr_r[AW-1:0];
        rd_vld_nxt   = ram_rd_en;
        chk_addr_nxt = addr_r[AW-1:0];
        if (ram_rd_en) begin
          addr_nxt = addr_r + CNT_W'(1);
        end
        if (rd_vld_r && rd_taken && rd_owner == pid_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = chk_addr_r;
          ram_wr_data = '0;
        end
        if (!rd_vld_r && !ram_rd_en) begin
          res_nxt.ok = 1'b1;
          state_nxt  = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r  <= chk_addr_nxt;
    run_r       <= run_nxt;
    len_r       <= len_nxt;
    last_r      <= last_nxt;
    end_r       <= end_nxt;
    mark_addr_r <= mark_addr_nxt;
    pid_r       <= pid_nxt;
    res_r       <= res_nxt;
    out_word_r  <= out_word_nxt;
  end

  // an accepted request always starts work or answers at once
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SCAN || state_r == ST_FREE || state_r == ST_RESP))
    else $error("accepted request did not start work");

  // the run counter never reaches the request size while scanning
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (run_r < len_r))
    else $error("run counter passed the request size");

  // marking stays inside the found run
  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (mark_addr_r <= end_r))
    else $error("mark pointer passed the end of the run");

  // a free only ever clears entries
  a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FREE && ram_wr_en) |-> (ram_wr_data == '0))
    else $error("free wrote a non-empty entry");

endmodule

`default_nettype wire
